// ===== sv/blfv_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery level package
// Field widths, curve tables and band thresholds for the battery level unit.
// ----------------------------------------------------------------------------
package blfv_pkg;

  localparam int MV_W   = 13;
  localparam int TEMP_W = 8;
  localparam int PCT_W  = 7;

  localparam int CURVE_POINTS = 6;
  localparam int TEMP_BANDS   = 3;

  localparam int BAND_W = (TEMP_BANDS > 1) ? $clog2(TEMP_BANDS) : 1;
  localparam int PT_W   = $clog2(CURVE_POINTS);

  typedef logic [MV_W-1:0]          mv_t;
  typedef logic [PCT_W-1:0]         pct_t;
  typedef logic signed [TEMP_W-1:0] temp_t;

  localparam pct_t FULL_PERCENT = pct_t'(100);

  // Bands are tried from warmest to coldest.
  localparam temp_t BAND_MIN_TEMP [TEMP_BANDS] = '{
    temp_t'(10), temp_t'(-5), temp_t'(-20)
  };

  localparam mv_t CURVE_MV [TEMP_BANDS][CURVE_POINTS] = '{
    '{mv_t'(3000), mv_t'(3400), mv_t'(3600), mv_t'(3700), mv_t'(3800), mv_t'(4150)},
    '{mv_t'(3000), mv_t'(3300), mv_t'(3400), mv_t'(3650), mv_t'(3750), mv_t'(4100)},
    '{mv_t'(3000), mv_t'(3100), mv_t'(3150), mv_t'(3350), mv_t'(3500), mv_t'(3900)}
  };

  localparam pct_t CURVE_PCT [TEMP_BANDS][CURVE_POINTS] = '{
    '{pct_t'(0), pct_t'(5), pct_t'(10), pct_t'(25), pct_t'(50), pct_t'(100)},
    '{pct_t'(0), pct_t'(5), pct_t'(10), pct_t'(25), pct_t'(50), pct_t'(100)},
    '{pct_t'(0), pct_t'(5), pct_t'(10), pct_t'(25), pct_t'(50), pct_t'(100)}
  };

endpackage

// ===== sv/blfv_reading_if.sv =====
// ----------------------------------------------------------------------------
// Battery reading channel
// Valid/ready channel that carries one voltage and temperature reading.
// ----------------------------------------------------------------------------
interface blfv_reading_if import blfv_pkg::*; ();
  logic  valid;
  logic  ready;
  mv_t   battery_millivolts;
  temp_t temperature_celsius;

  modport source (output valid, output battery_millivolts, output temperature_celsius,
                  input ready);
  modport sink   (input valid, input battery_millivolts, input temperature_celsius,
                  output ready);
endinterface

// ===== sv/blfv_level_if.sv =====
// ----------------------------------------------------------------------------
// Battery level channel
// Valid/ready channel that carries one charge percentage.
// ----------------------------------------------------------------------------
interface blfv_level_if import blfv_pkg::*; ();
  logic valid;
  logic ready;
  pct_t charge_percent;

  modport source (output valid, output charge_percent, input ready);
  modport sink   (input valid, input charge_percent, output ready);
endinterface

// ===== sv/battery_level_from_voltage_unit.sv =====
// Accepts one voltage/temperature reading per clock while the pipeline is not
// full and stalled, and returns one charge percentage per reading, in order.
// Each reading passes through the twelve register stages of the pipeline: band
// select, segment search, difference, multiply, seven one-bit restoring divide
// stages and the output register. Every stage holds its transaction while the
// stage after it is full and stalled, so empty stages keep taking new readings.
// ----------------------------------------------------------------------------
// Battery level from voltage
// Piecewise-linear state-of-charge estimate from voltage and temperature.
// ----------------------------------------------------------------------------
module battery_level_from_voltage_unit import blfv_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  blfv_reading_if.sink   reading,
  blfv_level_if.source   result
);

  localparam int QW     = PCT_W;          // quotient never exceeds the percent step within the curve
  localparam int PROD_W = MV_W + PCT_W;
  localparam int NST    = 4 + QW + 1;
  localparam int DIV0   = 4;

  logic [NST-1:0] v;
  logic [NST:0]   adv;

  always_comb begin
    adv[NST] = result.ready;
    for (int i = NST - 1; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign reading.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= reading.valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage 0: pick the temperature band and load its curve.
  logic [BAND_W-1:0] band;
  mv_t  s0_mv;
  mv_t  s0_cmv  [CURVE_POINTS];
  pct_t s0_cpct [CURVE_POINTS];

  always_comb begin
    band = BAND_W'(TEMP_BANDS - 1);
    for (int b = TEMP_BANDS - 2; b >= 0; b--) begin
      if (reading.temperature_celsius >= BAND_MIN_TEMP[b]) band = BAND_W'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_mv <= reading.battery_millivolts;
      for (int p = 0; p < CURVE_POINTS; p++) begin
        s0_cmv[p]  <= CURVE_MV[band][p];
        s0_cpct[p] <= CURVE_PCT[band][p];
      end
    end
  end

  // Stage 1: find the first segment that encloses the voltage.
  logic [PT_W-1:0] seg_lo;
  logic [PT_W-1:0] seg_hi;
  mv_t  s1_mv, s1_vlo, s1_vhi;
  pct_t s1_plo, s1_phi;
  logic s1_above, s1_below;

  always_comb begin
    seg_lo = PT_W'(CURVE_POINTS - 2);
    seg_hi = PT_W'(CURVE_POINTS - 1);
    for (int s = CURVE_POINTS - 2; s >= 0; s--) begin
      if (s0_mv >= s0_cmv[s] && s0_mv <= s0_cmv[s+1]) begin
        seg_lo = PT_W'(s);
        seg_hi = PT_W'(s + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_mv    <= s0_mv;
      s1_vlo   <= s0_cmv[seg_lo];
      s1_vhi   <= s0_cmv[seg_hi];
      s1_plo   <= s0_cpct[seg_lo];
      s1_phi   <= s0_cpct[seg_hi];
      s1_above <= s0_mv > s0_cmv[CURVE_POINTS-1];
      s1_below <= s0_mv < s0_cmv[0];
    end
  end

  // Stage 2: differences. A flat or falling segment, or a voltage below it,
  // divides zero by one, which leaves the lower percentage.
  logic plain;
  mv_t  s2_dv, s2_span;
  pct_t s2_dp, s2_plo;
  logic s2_above, s2_below;

  assign plain = (s1_vhi > s1_vlo) && (s1_mv >= s1_vlo) && (s1_phi >= s1_plo);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_dv    <= plain ? mv_t'(s1_mv - s1_vlo) : '0;
      s2_span  <= plain ? mv_t'(s1_vhi - s1_vlo) : mv_t'(1);
      s2_dp    <= plain ? pct_t'(s1_phi - s1_plo) : '0;
      s2_plo   <= s1_plo;
      s2_above <= s1_above;
      s2_below <= s1_below;
    end
  end

  // Stage 3 (index 0 of the arrays) is the product; the rest are divide stages.
  logic [PROD_W-1:0] rem   [QW+1];
  mv_t               span  [QW+1];
  pct_t              plo   [QW+1];
  logic [QW-1:0]     quo   [QW+1];
  logic              above [QW+1];
  logic              below [QW+1];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      rem[0]   <= PROD_W'(s2_dp) * PROD_W'(s2_dv);
      span[0]  <= s2_span;
      plo[0]   <= s2_plo;
      quo[0]   <= '0;
      above[0] <= s2_above;
      below[0] <= s2_below;
    end
  end

  for (genvar d = 0; d < QW; d++) begin : g_div
    localparam int K = QW - 1 - d;
    logic [PROD_W-1:0] trial;
    logic              take;

    assign trial = PROD_W'(span[d]) << K;
    assign take  = rem[d] >= trial;

    always_ff @(posedge clk) begin
      if (adv[DIV0+d]) begin
        rem[d+1]   <= take ? PROD_W'(rem[d] - trial) : rem[d];
        span[d+1]  <= span[d];
        plo[d+1]   <= plo[d];
        quo[d+1]   <= quo[d] | (take ? QW'(1) << K : QW'(0));
        above[d+1] <= above[d];
        below[d+1] <= below[d];
      end
    end
  end

  // Output stage: add the base percentage, clamp the ends and saturate.
  logic [PCT_W:0] sum;
  pct_t           level_next;
  pct_t           level;

  always_comb begin
    sum = (PCT_W+1)'(plo[QW]) + (PCT_W+1)'(quo[QW]);
    if (above[QW]) begin
      level_next = FULL_PERCENT;
    end else if (below[QW]) begin
      level_next = '0;
    end else if (sum > (PCT_W+1)'(FULL_PERCENT)) begin
      level_next = FULL_PERCENT;
    end else begin
      level_next = sum[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NST-1]) level <= level_next;
  end

  assign result.valid          = v[NST-1];
  assign result.charge_percent = level;

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.charge_percent <= FULL_PERCENT)
    else $error("charge percentage above full scale");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&v) && !result.ready |-> !reading.ready)
    else $error("reading taken while the pipeline is full and stalled");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    v[NST-2] |-> !(above[QW] && below[QW]))
    else $error("voltage flagged both above and below the curve");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && v[NST-2] |=> result.valid)
    else $error("result lost while draining the pipeline");
`endif

endmodule
